// ===== hw/rtl/spsc_pkg.sv =====
// ============================================================================
// Scan pattern syntax checker package
// Shared types, codes and default sizes for the pattern syntax checker.
// ============================================================================
package spsc_pkg;

   // Defaults for the top-level parameters.
   localparam int DEPTH_LIMIT_DEFAULT     = 8;
   localparam int STORE_LIMIT_DEFAULT     = 8;
   localparam int MAX_PATTERN_LEN_DEFAULT = 4096;

   localparam int CH_W     = 8;
   localparam int STATUS_W = 3;
   localparam int POS_W    = 12;
   localparam int COUNT_W  = 4;

   // Parser mode between characters.
   typedef enum logic [2:0] {
      MODE_TOP        = 3'd0,
      MODE_AFTER_PLUS = 3'd1,
      MODE_NEED_SIZE  = 3'd2,
      MODE_NEED_HEX2  = 3'd3,
      MODE_IN_QUOTE   = 3'd4
   } mode_type;

   // Verdict codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK             = 3'd0,
      ST_UNEXPECTED_END = 3'd1,
      ST_BAD_RECURSION  = 3'd2,
      ST_BAD_SIZE       = 3'd3,
      ST_UNPAIRED_HEX   = 3'd4,
      ST_UNKNOWN_CHAR   = 3'd5,
      ST_STACK          = 3'd6,
      ST_STORE_OVERFLOW = 3'd7
   } status_type;

   typedef struct packed {
      mode_type             mode;
      logic                 quote_is_double;
      logic [COUNT_W-1:0]   nest_depth;
      logic [COUNT_W-1:0]   store_count;
      logic [POS_W-1:0]     char_index;
      logic [POS_W-1:0]     plus_index;
      logic                 failed;
   } parse_state_type;

   typedef struct packed {
      status_type           status;
      logic [POS_W-1:0]     error_pos;
   } verdict_type;

   localparam parse_state_type PARSE_STATE_RESET = '{
      mode:            MODE_TOP,
      quote_is_double: 1'b0,
      nest_depth:      '0,
      store_count:     '0,
      char_index:      '0,
      plus_index:      '0,
      failed:          1'b0
   };

endpackage

// ===== hw/rtl/spsc_req_if.sv =====
// ============================================================================
// Pattern character channel
// Valid/ready channel that carries one pattern character per transaction.
// ============================================================================
interface spsc_req_if;
   import spsc_pkg::*;

   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

// ===== hw/rtl/spsc_rsp_if.sv =====
// ============================================================================
// Verdict channel
// Valid/ready channel that carries one syntax verdict per transaction.
// ============================================================================
interface spsc_rsp_if;
   import spsc_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [POS_W-1:0]    error_pos;

   modport source (output valid, output status, output error_pos, input ready);
   modport sink   (input valid, input status, input error_pos, output ready);
endinterface

// ===== hw/rtl/spsc_char_step.sv =====
// ============================================================================
// Pattern character step
// Combinational parser update for one character: next state and verdict.
// ============================================================================
module spsc_char_step #(
   parameter int DEPTH_LIMIT     = spsc_pkg::DEPTH_LIMIT_DEFAULT,
   parameter int STORE_LIMIT     = spsc_pkg::STORE_LIMIT_DEFAULT,
   parameter int MAX_PATTERN_LEN = spsc_pkg::MAX_PATTERN_LEN_DEFAULT
) (
   input  logic [spsc_pkg::CH_W-1:0] ch,
   input  spsc_pkg::parse_state_type cur_state,
   output spsc_pkg::parse_state_type nxt_state,
   output logic                      verdict_valid,
   output spsc_pkg::verdict_type     verdict
);
   import spsc_pkg::*;

   localparam int POS_MAX_INT = (MAX_PATTERN_LEN - 1 < 4095) ? MAX_PATTERN_LEN - 1 : 4095;
   localparam logic [POS_W-1:0]   POS_MAX   = POS_W'(POS_MAX_INT);
   localparam logic [COUNT_W-1:0] DEPTH_MAX = COUNT_W'(DEPTH_LIMIT);
   localparam logic [COUNT_W-1:0] STORE_MAX = COUNT_W'(STORE_LIMIT);

   localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
   localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;
   localparam logic [CH_W-1:0] CH_SQUOTE = 8'h27;
   localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CH_W-1:0] CH_ONE    = 8'h31;
   localparam logic [CH_W-1:0] CH_TWO    = 8'h32;
   localparam logic [CH_W-1:0] CH_FOUR   = 8'h34;
   localparam logic [CH_W-1:0] CH_QMARK  = 8'h3F;
   localparam logic [CH_W-1:0] CH_UP_J   = 8'h4A;
   localparam logic [CH_W-1:0] CH_UP_R   = 8'h52;
   localparam logic [CH_W-1:0] CH_LO_J   = 8'h6A;
   localparam logic [CH_W-1:0] CH_LO_R   = 8'h72;

   function automatic logic is_hex(input logic [CH_W-1:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   logic is_end;
   logic is_j;
   logic is_r;
   logic [CH_W-1:0] close_quote;

   assign is_end      = (ch == CH_NUL);
   assign is_j        = (ch == CH_LO_J) || (ch == CH_UP_J);
   assign is_r        = (ch == CH_LO_R) || (ch == CH_UP_R);
   assign close_quote = cur_state.quote_is_double ? CH_DQUOTE : CH_SQUOTE;

   always_comb begin
      nxt_state         = cur_state;
      verdict_valid     = 1'b0;
      verdict.status    = ST_OK;
      verdict.error_pos = cur_state.char_index;

      if (cur_state.failed) begin
         // Swallow the rest of a failed pattern; the terminator rearms.
         if (is_end) begin
            nxt_state = PARSE_STATE_RESET;
         end
      end else begin
         unique case (cur_state.mode)
            MODE_AFTER_PLUS: begin
               if (is_end) begin
                  verdict_valid     = 1'b1;
                  verdict.status    = ST_UNEXPECTED_END;
                  verdict.error_pos = cur_state.plus_index;
               end else if (is_j) begin
                  nxt_state.mode = MODE_TOP;
               end else if (is_r) begin
                  nxt_state.mode = MODE_NEED_SIZE;
               end else begin
                  verdict_valid     = 1'b1;
                  verdict.status    = ST_BAD_RECURSION;
                  verdict.error_pos = cur_state.plus_index;
               end
            end
            MODE_NEED_SIZE: begin
               if (is_end) begin
                  verdict_valid  = 1'b1;
                  verdict.status = ST_UNEXPECTED_END;
               end else if (ch == CH_ONE || ch == CH_TWO || ch == CH_FOUR) begin
                  nxt_state.mode = MODE_TOP;
               end else begin
                  verdict_valid  = 1'b1;
                  verdict.status = ST_BAD_SIZE;
               end
            end
            MODE_NEED_HEX2: begin
               if (is_end) begin
                  verdict_valid  = 1'b1;
                  verdict.status = ST_UNEXPECTED_END;
               end else if (is_hex(ch)) begin
                  nxt_state.mode = MODE_TOP;
               end else begin
                  verdict_valid  = 1'b1;
                  verdict.status = ST_UNPAIRED_HEX;
               end
            end
            MODE_IN_QUOTE: begin
               if (is_end) begin
                  verdict_valid  = 1'b1;
                  verdict.status = ST_UNEXPECTED_END;
               end else if (ch == close_quote) begin
                  nxt_state.mode = MODE_TOP;
               end
            end
            default: begin
               if (is_end) begin
                  verdict_valid  = 1'b1;
                  verdict.status = (cur_state.nest_depth != '0) ? ST_STACK : ST_OK;
               end else if (ch == CH_PLUS) begin
                  if (cur_state.nest_depth >= DEPTH_MAX) begin
                     verdict_valid  = 1'b1;
                     verdict.status = ST_STACK;
                  end else begin
                     nxt_state.nest_depth = cur_state.nest_depth + COUNT_W'(1);
                     nxt_state.plus_index = cur_state.char_index;
                     nxt_state.mode       = MODE_AFTER_PLUS;
                  end
               end else if (ch == CH_MINUS) begin
                  if (cur_state.nest_depth == '0) begin
                     verdict_valid  = 1'b1;
                     verdict.status = ST_STACK;
                  end else begin
                     nxt_state.nest_depth = cur_state.nest_depth - COUNT_W'(1);
                  end
               end else if (is_r) begin
                  nxt_state.mode = MODE_NEED_SIZE;
               end else if (is_hex(ch)) begin
                  nxt_state.mode = MODE_NEED_HEX2;
               end else if (ch == CH_SQUOTE || ch == CH_DQUOTE) begin
                  nxt_state.quote_is_double = (ch == CH_DQUOTE);
                  nxt_state.mode            = MODE_IN_QUOTE;
               end else if (ch == CH_STAR) begin
                  if (cur_state.store_count >= STORE_MAX) begin
                     verdict_valid  = 1'b1;
                     verdict.status = ST_STORE_OVERFLOW;
                  end else begin
                     nxt_state.store_count = cur_state.store_count + COUNT_W'(1);
                  end
               end else if (ch == CH_SPACE || ch == CH_QMARK || is_j) begin
                  nxt_state.mode = MODE_TOP;
               end else begin
                  verdict_valid  = 1'b1;
                  verdict.status = ST_UNKNOWN_CHAR;
               end
            end
         endcase

         if (cur_state.char_index < POS_MAX) begin
            nxt_state.char_index = cur_state.char_index + POS_W'(1);
         end

         if (is_end) begin
            nxt_state = PARSE_STATE_RESET;
         end else if (verdict_valid) begin
            nxt_state.failed = 1'b1;
         end
      end
   end

endmodule

// ===== hw/rtl/scan_pattern_syntax_checker_unit.sv =====
// ============================================================================
// Scan pattern syntax checker
// Checks a byte-signature pattern streamed one character per transaction.
// ============================================================================
// Path: a character waits in the input register; its verdict, in the verdict register.
// Throughput: one character per cycle while the output register is free;
// the parser update is a single pass of short logic between the input
// register and the state/verdict registers.
// Reset: synchronous, active high; clears the parser state and both stages.
// ============================================================================
module scan_pattern_syntax_checker_unit #(
   parameter int DEPTH_LIMIT     = spsc_pkg::DEPTH_LIMIT_DEFAULT,
   parameter int STORE_LIMIT     = spsc_pkg::STORE_LIMIT_DEFAULT,
   parameter int MAX_PATTERN_LEN = spsc_pkg::MAX_PATTERN_LEN_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   spsc_req_if.sink   req_if,
   spsc_rsp_if.source rsp_if
);
   import spsc_pkg::*;

   // Input stage: one character waiting to be parsed.
   logic             in_valid_ff;
   logic             in_valid_in;
   logic [CH_W-1:0]  in_ch_ff;

   // Parser state carried from character to character.
   parse_state_type  state_ff;
   parse_state_type  state_in;

   // Output stage: one verdict waiting to be taken.
   logic             out_valid_ff;
   logic             out_valid_in;
   verdict_type      out_verdict_ff;

   logic             step_verdict_valid;
   verdict_type      step_verdict;
   logic             out_free;
   logic             step_fire;
   logic             req_fire;

   // The output register is free when it is empty or is being drained this
   // cycle. A character in the input stage is parsed only when a verdict it
   // might produce has a place to go, so stalls never lose a verdict.
   assign out_free  = !out_valid_ff || rsp_if.ready;
   assign step_fire = in_valid_ff && out_free;
   assign req_fire  = req_if.valid && req_if.ready;

   // The input stage takes a new transaction whenever it is empty or its
   // current character is parsed in this same cycle.
   assign req_if.ready = !in_valid_ff || out_free;

   spsc_char_step #(
      .DEPTH_LIMIT     (DEPTH_LIMIT),
      .STORE_LIMIT     (STORE_LIMIT),
      .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
   ) u_step (
      .ch            (in_ch_ff),
      .cur_state     (state_ff),
      .nxt_state     (state_in),
      .verdict_valid (step_verdict_valid),
      .verdict       (step_verdict)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (step_fire) begin
         out_valid_in = step_verdict_valid;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= PARSE_STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step_fire) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ch_ff <= req_if.ch;
      end
      if (step_fire && step_verdict_valid) begin
         out_verdict_ff <= step_verdict;
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.status    = out_verdict_ff.status;
   assign rsp_if.error_pos = out_verdict_ff.error_pos;

endmodule
